### design/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared constants and types for the heading PID steering block.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned HEAD_W = 15;

  localparam logic [HEAD_W-1:0] HEAD_FULL = 15'd23040;
  localparam logic [HEAD_W-1:0] HEAD_HALF = 15'd11520;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 39;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE = 3'd5;

  typedef struct packed {
    logic obstacle;
    logic estop;
  } hps_flags_t;

endpackage

### design/hps_head_err.sv
// ----------------------------------------------------------------------------
// hps_head_err
// Wrapped heading error between target and measured heading, 1/64 degree.
// ----------------------------------------------------------------------------
module hps_head_err (
  input  logic        [hps_pkg::HEAD_W-1:0] target,
  input  logic        [hps_pkg::HEAD_W-1:0] measured,
  output logic signed [hps_pkg::HEAD_W-1:0] err
);

  logic [hps_pkg::HEAD_W-1:0] set_c;
  logic [hps_pkg::HEAD_W-1:0] meas_c;
  logic [hps_pkg::HEAD_W-1:0] diff;
  logic [hps_pkg::HEAD_W-1:0] alt;
  logic [hps_pkg::HEAD_W-1:0] mag;
  logic [hps_pkg::HEAD_W:0]   set_hi;
  logic                       neg;

  always_comb begin
    set_c  = (target > hps_pkg::HEAD_FULL) ? hps_pkg::HEAD_FULL : target;
    meas_c = (measured > hps_pkg::HEAD_FULL) ? hps_pkg::HEAD_FULL : measured;
    diff   = (set_c > meas_c) ? (set_c - meas_c) : (meas_c - set_c);
    alt    = hps_pkg::HEAD_FULL - diff;
    mag    = (diff < alt) ? diff : alt;
    set_hi = {1'b0, set_c} + {1'b0, hps_pkg::HEAD_HALF};
    if (set_c <= hps_pkg::HEAD_HALF) begin
      neg = ({1'b0, meas_c} <= set_hi) && (meas_c >= set_c);
    end else begin
      neg = (meas_c >= set_c) || (meas_c <= (set_c - hps_pkg::HEAD_HALF));
    end
    err = neg ? -$signed(mag) : $signed(mag);
  end

endmodule

### design/heading_pid_steering_top.sv
// ----------------------------------------------------------------------------
// heading_pid_steering_top
// Heading PID steering: wrapped error, saturating integrator, PID turn rate,
// e-stop and sonar obstacle halt.
//
//   channel | handshake              | word
//   --------+------------------------+-----------------------------------------
//   in      | in_valid / in_ready    | headings, three sonar ranges, estop
//   out     | out_valid / out_ready  | speed, turn, error, obstacle, estop flag
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One word per cycle sustained while out_ready holds; a word passes the input
// register, error/integrator, multiply, integral combine, then sum and
// saturate into the output register. Integrator and last error advance as a
// word leaves the input register. Each stage holds while the next is full and
// stalled; a stalled output fills all five stages and then drops in_ready.
// Reset is synchronous, active low; valids, configuration and integrator state
// come up at their reset values, while stage data registers are not reset.
// ----------------------------------------------------------------------------
module heading_pid_steering_top (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [14:0]                   in_target_heading,
  input  logic        [14:0]                   in_measured_heading,
  input  logic        [15:0]                   in_dist_center,
  input  logic        [15:0]                   in_dist_left,
  input  logic        [15:0]                   in_dist_right,
  input  logic                                 in_estop,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_forward_speed,
  output logic signed [15:0]                   out_turn_rate,
  output logic signed [14:0]                   out_heading_error,
  output logic                                 out_obstacle_stop,
  output logic                                 out_estop_active,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [hps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [71:0] IMAG_CAP = 72'd1 << 60;

  // configuration
  logic        [31:0] prop_gain_r;
  logic        [31:0] deriv_gain_r;
  logic        [31:0] integ_gain_r;
  logic        [38:0] integ_limit_r;
  logic signed [15:0] cruise_speed_r;
  logic        [15:0] stop_distance_r;

  // state
  logic signed [39:0] error_sum_r;
  logic signed [14:0] last_error_r;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic go1, go2, go3, go4, go_o;

  // stage 1: input register
  logic [14:0] tgt_s1_r, meas_s1_r;
  logic [15:0] dc_s1_r, dl_s1_r, dr_s1_r;
  logic        estop_s1_r;

  // stage 2
  logic signed [14:0] e_s2_r;
  logic signed [15:0] de_s2_r;
  logic        [38:0] mag_s2_r;
  logic               neg_s2_r;
  hps_pkg::hps_flags_t flags_s2_r;

  // stage 3
  logic signed [47:0] pe_s3_r;
  logic signed [48:0] pd_s3_r;
  logic        [51:0] pil_s3_r;
  logic        [50:0] pih_s3_r;
  logic               neg_s3_r;
  logic signed [14:0] e_s3_r;
  hps_pkg::hps_flags_t flags_s3_r;

  // stage 4
  logic signed [49:0] pp_s4_r;
  logic signed [61:0] iterm_s4_r;
  logic signed [14:0] e_s4_r;
  hps_pkg::hps_flags_t flags_s4_r;

  // output register
  logic signed [15:0] speed_o_r, turn_o_r;
  logic signed [14:0] e_o_r;
  hps_pkg::hps_flags_t flags_o_r;

  // combinational
  logic signed [14:0] e_nxt;
  logic signed [40:0] sum_wide;
  logic signed [39:0] error_sum_nxt;
  logic signed [15:0] de_nxt;
  logic signed [39:0] lim_pos, lim_neg, clamp_v;
  logic        [39:0] clamp_abs;
  logic               obstacle_nxt;
  logic signed [47:0] pe_nxt;
  logic signed [48:0] pd_nxt;
  logic        [71:0] imag;
  logic        [71:0] imag_sat;
  logic signed [61:0] iterm_nxt;
  logic signed [49:0] pp_nxt;
  logic signed [63:0] s_sum;
  logic signed [39:0] q_val;
  logic signed [15:0] turn_nxt;
  logic               halted;

  assign go_o     = !vo_r || out_ready;
  assign go4      = !v4_r || go_o;
  assign go3      = !v3_r || go4;
  assign go2      = !v2_r || go3;
  assign go1      = !v1_r || go2;
  assign in_ready = go1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= 32'd6710886;
      deriv_gain_r    <= 32'd335544;
      integ_gain_r    <= 32'd201;
      integ_limit_r   <= 39'd6400000;
      cruise_speed_r  <= 16'sd0;
      stop_distance_r <= 16'd18;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hps_pkg::CFG_PROP_GAIN:     prop_gain_r     <= cfg_data[31:0];
        hps_pkg::CFG_DERIV_GAIN:    deriv_gain_r    <= cfg_data[31:0];
        hps_pkg::CFG_INTEG_GAIN:    integ_gain_r    <= cfg_data[31:0];
        hps_pkg::CFG_INTEG_LIMIT:   integ_limit_r   <= cfg_data[38:0];
        hps_pkg::CFG_CRUISE_SPEED:  cruise_speed_r  <= $signed(cfg_data[15:0]);
        hps_pkg::CFG_STOP_DISTANCE: stop_distance_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hps_head_err u_head_err (
    .target   (tgt_s1_r),
    .measured (meas_s1_r),
    .err      (e_nxt)
  );

  always_comb begin
    sum_wide = $signed({error_sum_r[39], error_sum_r}) + 41'(e_nxt);
    if (sum_wide[40] != sum_wide[39]) begin
      error_sum_nxt = sum_wide[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      error_sum_nxt = sum_wide[39:0];
    end
    de_nxt  = 16'(e_nxt) - 16'(last_error_r);
    lim_pos = $signed({1'b0, integ_limit_r});
    lim_neg = -lim_pos;
    if (error_sum_nxt > lim_neg) begin
      clamp_v = (error_sum_nxt < lim_pos) ? error_sum_nxt : lim_pos;
    end else begin
      clamp_v = lim_neg;
    end
    clamp_abs    = clamp_v[39] ? 40'(-clamp_v) : 40'(clamp_v);
    obstacle_nxt = (dc_s1_r < stop_distance_r) || (dl_s1_r < stop_distance_r) ||
                   (dr_s1_r < stop_distance_r);
  end

  always_comb begin
    pe_nxt = $signed({1'b0, prop_gain_r}) * e_s2_r;
    pd_nxt = $signed({1'b0, deriv_gain_r}) * de_s2_r;
  end

  always_comb begin
    imag      = {1'b0, pih_s3_r, 20'd0} + {20'd0, pil_s3_r};
    imag_sat  = (imag > IMAG_CAP) ? IMAG_CAP : imag;
    iterm_nxt = neg_s3_r ? -$signed({1'b0, imag_sat[60:0]}) : $signed({1'b0, imag_sat[60:0]});
    pp_nxt    = 50'(pe_s3_r) + 50'(pd_s3_r);
  end

  always_comb begin
    s_sum = 64'(pp_s4_r) + 64'(iterm_s4_r) + 64'sd8388608;
    q_val = s_sum[63:24];
    if (q_val > 40'sd32767) begin
      turn_nxt = 16'sd32767;
    end else if (q_val < -40'sd32768) begin
      turn_nxt = -16'sd32768;
    end else begin
      turn_nxt = q_val[15:0];
    end
    halted = flags_s4_r.obstacle || flags_s4_r.estop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      vo_r         <= 1'b0;
      error_sum_r  <= 40'sd0;
      last_error_r <= 15'sd0;
    end else begin
      if (go1) v1_r <= in_valid;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
      if (go4) v4_r <= v3_r;
      if (go_o) vo_r <= v4_r;
      if (v1_r && go2) begin
        error_sum_r  <= error_sum_nxt;
        last_error_r <= e_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && go1) begin
      tgt_s1_r   <= in_target_heading;
      meas_s1_r  <= in_measured_heading;
      dc_s1_r    <= in_dist_center;
      dl_s1_r    <= in_dist_left;
      dr_s1_r    <= in_dist_right;
      estop_s1_r <= in_estop;
    end
    if (v1_r && go2) begin
      e_s2_r              <= e_nxt;
      de_s2_r             <= de_nxt;
      mag_s2_r            <= clamp_abs[38:0];
      neg_s2_r            <= clamp_v[39];
      flags_s2_r.obstacle <= obstacle_nxt;
      flags_s2_r.estop    <= estop_s1_r;
    end
    if (v2_r && go3) begin
      pe_s3_r    <= pe_nxt;
      pd_s3_r    <= pd_nxt;
      pil_s3_r   <= integ_gain_r * mag_s2_r[19:0];
      pih_s3_r   <= integ_gain_r * mag_s2_r[38:20];
      neg_s3_r   <= neg_s2_r;
      e_s3_r     <= e_s2_r;
      flags_s3_r <= flags_s2_r;
    end
    if (v3_r && go4) begin
      pp_s4_r    <= pp_nxt;
      iterm_s4_r <= iterm_nxt;
      e_s4_r     <= e_s3_r;
      flags_s4_r <= flags_s3_r;
    end
    if (v4_r && go_o) begin
      speed_o_r <= halted ? 16'sd0 : cruise_speed_r;
      turn_o_r  <= halted ? 16'sd0 : turn_nxt;
      e_o_r     <= e_s4_r;
      flags_o_r <= flags_s4_r;
    end
  end

  assign out_valid         = vo_r;
  assign out_forward_speed = speed_o_r;
  assign out_turn_rate     = turn_o_r;
  assign out_heading_error = e_o_r;
  assign out_obstacle_stop = flags_o_r.obstacle;
  assign out_estop_active  = flags_o_r.estop;

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r && go2) |=> ($stable(last_error_r) && $stable(error_sum_r)))
    else $error("integrator state changed without a word");

  a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_obstacle_stop || out_estop_active)) |->
    (out_forward_speed == 16'sd0 && out_turn_rate == 16'sd0))
    else $error("halted word carries nonzero speed or turn");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_error >= -15'sd11520 && out_heading_error <= 15'sd11520))
    else $error("heading error out of range");
`endif

endmodule
